/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion shorthands
// Each macro expects signals clk and arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pbl_pkg.sv */
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared types and constants of the positional byte list.
// ----------------------------------------------------------------------------
package pbl_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 5;
	localparam int DATA_W   = 8;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_GET    = 2'd2,
		MODE_LOCATE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_cmd;
		logic exec;
		logic find;
		logic load_out;
	} pbl_cmd_t;

	typedef struct packed {
		logic is_locate;
		logic out_free;
	} pbl_stat_t;

endpackage

/* hw/rtl/pbl_ctrl.sv */
// ----------------------------------------------------------------------------
// pbl_ctrl
// Sequencer: accept a command, execute it, search if needed, post the result.
// ----------------------------------------------------------------------------
module pbl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pbl_pkg::pbl_stat_t stat,
	output pbl_pkg::pbl_cmd_t  cmd
);
	import pbl_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_cmd = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.is_locate ? ST_FIND : ST_DONE;
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/pbl_datapath.sv */
// ----------------------------------------------------------------------------
// pbl_datapath
// List cells with parallel shift, match vector, result and output registers.
// ----------------------------------------------------------------------------
module pbl_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbl_pkg::pbl_cmd_t             cmd,
	output pbl_pkg::pbl_stat_t            stat,
	input  logic [1:0]                    mode,
	input  logic [pbl_pkg::POS_W-1:0]     position,
	input  logic [pbl_pkg::DATA_W-1:0]    value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [pbl_pkg::DATA_W-1:0]    item,
	output logic [pbl_pkg::POS_W-1:0]     found_at,
	output logic [pbl_pkg::POS_W-1:0]     count,
	output logic                          empty_res
);
	import pbl_pkg::*;

	mode_t                 mode_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_W-1:0]     val_q;
	logic [DATA_W-1:0]     cells_q [CAPACITY];
	logic [CNT_W-1:0]      len_q;
	logic [CAPACITY-1:0]   match_q;
	logic                  res_ok_q;
	logic [DATA_W-1:0]     res_item_q;
	logic [POS_W-1:0]      res_found_q;
	logic                  out_valid_q;

	logic [CMP_W-1:0]      pos_c;
	logic [CMP_W-1:0]      len_c;
	logic                  rd_ok;
	logic                  ins_ok;
	logic                  del_ok;
	logic                  get_ok;
	logic [IDX_W-1:0]      rd_idx;
	logic [DATA_W-1:0]     rd_item;
	logic [POS_W-1:0]      find_pos;

	assign pos_c   = CMP_W'(pos_q);
	assign len_c   = CMP_W'(len_q);
	assign rd_ok   = (pos_c != '0) && (pos_c <= len_c);
	assign ins_ok  = (mode_q == MODE_INSERT) && (pos_c != '0) &&
	                 (pos_c <= len_c + CMP_W'(1)) && (len_c < CMP_W'(CAPACITY));
	assign del_ok  = (mode_q == MODE_DELETE) && rd_ok;
	assign get_ok  = (mode_q == MODE_GET) && rd_ok;
	assign rd_idx  = IDX_W'(pos_c - CMP_W'(1));
	assign rd_item = cells_q[rd_idx];

	assign stat.is_locate = (mode_q == MODE_LOCATE);
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_cmd) begin
			mode_q <= mode_t'(mode);
			pos_q  <= position;
			val_q  <= value;
		end
	end

	// each cell takes the new byte, its left neighbor or its right neighbor
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		localparam logic [CMP_W-1:0] KC = CMP_W'(k);
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (ins_ok) begin
					if (KC + CMP_W'(1) == pos_c) begin
						cells_q[k] <= val_q;
					end else if ((KC + CMP_W'(1) > pos_c) && (KC <= len_c)) begin
						if (k > 0) begin
							cells_q[k] <= cells_q[(k > 0) ? k - 1 : 0];
						end
					end
				end else if (del_ok) begin
					if ((KC + CMP_W'(1) >= pos_c) && (KC + CMP_W'(1) < len_c)) begin
						if (k < CAPACITY - 1) begin
							cells_q[k] <= cells_q[(k < CAPACITY - 1) ? k + 1 : k];
						end
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				match_q[k] <= (KC < len_c) && (cells_q[k] == val_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.exec) begin
			if (ins_ok) begin
				len_q <= len_q + CNT_W'(1);
			end else if (del_ok) begin
				len_q <= len_q - CNT_W'(1);
			end
		end
	end

	// lowest matching cell wins
	always_comb begin
		find_pos = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (match_q[k]) begin
				find_pos = POS_W'(k + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_ok_q    <= ins_ok || del_ok || get_ok;
			res_item_q  <= (del_ok || get_ok) ? rd_item : '0;
			res_found_q <= '0;
		end else if (cmd.find) begin
			res_ok_q    <= |match_q;
			res_item_q  <= '0;
			res_found_q <= find_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ok        <= res_ok_q;
			item      <= res_item_q;
			found_at  <= res_found_q;
			count     <= POS_W'(len_q);
			empty_res <= (len_q == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/positional_byte_list.sv */
// ----------------------------------------------------------------------------
// positional_byte_list
// Ordered list of up to CAPACITY bytes addressed by one-based position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command: mode, position,
//   value. Modes: insert, delete, get, locate. Output channel
//   (out_valid/out_ready) returns one result per command: ok, item,
//   found_at, count, empty_res.
//   Each command passes the sequencer states accept, execute and result
//   post; locate adds a search state between execute and post, in which
//   the registered match vector feeds the priority encoder.
//   The sequencer works one command at a time through accept, execute,
//   optional search and result post, so a new command is accepted only
//   after the previous result has been posted.
//   All cells shift in parallel during the execute cycle.
//   Reset clears the length and the handshake state; cell contents are
//   left undefined and are never read before being written.
//   When the receiver stalls, the result holds in the output register and
//   one further command may be accepted and executed; its result waits in
//   the result registers until the output register frees.
// ----------------------------------------------------------------------------
module positional_byte_list (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 mode,
	input  logic [pbl_pkg::POS_W-1:0]  position,
	input  logic [pbl_pkg::DATA_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       ok,
	output logic [pbl_pkg::DATA_W-1:0] item,
	output logic [pbl_pkg::POS_W-1:0]  found_at,
	output logic [pbl_pkg::POS_W-1:0]  count,
	output logic                       empty_res
);
	import pbl_pkg::*;

	pbl_cmd_t  cmd;
	pbl_stat_t stat;

	pbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pbl_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mode      (mode),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ok        (ok),
		.item      (item),
		.found_at  (found_at),
		.count     (count),
		.empty_res (empty_res)
	);

endmodule

/* hw/rtl/pbl_checker.sv */
// ----------------------------------------------------------------------------
// pbl_checker
// Port-level checks on the positional byte list, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       ok,
	input logic [pbl_pkg::DATA_W-1:0] item,
	input logic [pbl_pkg::POS_W-1:0]  found_at,
	input logic [pbl_pkg::POS_W-1:0]  count,
	input logic                       empty_res
);
	import pbl_pkg::*;

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(count), "result dropped while stalled")
	`ASSERT_IMPLY(a_empty_flag, out_valid, empty_res == (count == '0), "empty flag disagrees with count")
	`ASSERT_IMPLY(a_fail_zero, out_valid && !ok, (item == '0) && (found_at == '0), "failed transaction carries data")
	`ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second transaction taken during execute")
	`ASSERT_IMPLY(a_count_cap, out_valid, (count <= POS_W'(CAPACITY)) && (found_at <= count), "count or position beyond list")

endmodule

bind positional_byte_list pbl_checker u_pbl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ok        (ok),
	.item      (item),
	.found_at  (found_at),
	.count     (count),
	.empty_res (empty_res)
);
